// File: rtl/core/aic_pkg.sv
`timescale 1ns / 1ps
// Package of the instruction classifier: mnemonic codes, operand form codes,
// flag bit positions and the decoded-request record. No dependencies.
package aic_pkg;

    typedef logic [5:0] mnem_t;
    typedef logic [2:0] form_t;

    localparam mnem_t MN_UNDEF = 6'd0;
    localparam mnem_t MN_BLX   = 6'd1;
    localparam mnem_t MN_BX    = 6'd2;
    localparam mnem_t MN_MUL   = 6'd3;
    localparam mnem_t MN_MLA   = 6'd4;
    localparam mnem_t MN_UMULL = 6'd5;
    localparam mnem_t MN_BKPT  = 6'd9;
    localparam mnem_t MN_SWP   = 6'd10;
    localparam mnem_t MN_LDRH0 = 6'd10; // base: ldrh/ldrsb/ldrsh = base + kind
    localparam mnem_t MN_STRH  = 6'd14;
    localparam mnem_t MN_LDRD  = 6'd15;
    localparam mnem_t MN_STRD  = 6'd16;
    localparam mnem_t MN_MRS   = 6'd17;
    localparam mnem_t MN_MSR   = 6'd18;
    localparam mnem_t MN_AND   = 6'd19; // data processing = and + opcode
    localparam mnem_t MN_LDR   = 6'd35;
    localparam mnem_t MN_STR   = 6'd36;
    localparam mnem_t MN_LDM   = 6'd37;
    localparam mnem_t MN_STM   = 6'd38;
    localparam mnem_t MN_B     = 6'd39;
    localparam mnem_t MN_BL    = 6'd40;
    localparam mnem_t MN_MCRR  = 6'd41;
    localparam mnem_t MN_MRRC  = 6'd42;
    localparam mnem_t MN_STC   = 6'd43;
    localparam mnem_t MN_LDC   = 6'd44;
    localparam mnem_t MN_SWI   = 6'd45;
    localparam mnem_t MN_MCR   = 6'd46;
    localparam mnem_t MN_MRC   = 6'd47;
    localparam mnem_t MN_CDP   = 6'd48;

    localparam form_t FORM_NONE  = 3'd0;
    localparam form_t FORM_IMM   = 3'd1;
    localparam form_t FORM_REG   = 3'd2;
    localparam form_t FORM_SHIMM = 3'd3;
    localparam form_t FORM_SHREG = 3'd4;
    localparam form_t FORM_RRX   = 3'd5;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam int unsigned FB_S   = 0;
    localparam int unsigned FB_BL  = 1;
    localparam int unsigned FB_T   = 2;
    localparam int unsigned FB_W   = 3;
    localparam int unsigned FB_P   = 4;
    localparam int unsigned FB_U   = 5;
    localparam int unsigned FB_PSR = 6;
    localparam int unsigned FB_MF  = 7;
    localparam int unsigned FB_MS  = 8;
    localparam int unsigned FB_MX  = 9;
    localparam int unsigned FB_MC  = 10;

    localparam logic [31:0] PC_AHEAD = 32'd8;

    typedef struct packed {
        logic [31:0] tgt;
        logic [31:0] val;
        logic [5:0]  amt;
        logic [1:0]  kind;
        form_t       form;
        logic [3:0]  rs;
        logic [3:0]  rm;
        logic [3:0]  rn;
        logic [3:0]  rd;
        logic [10:0] flags;
        logic [3:0]  cond;
        mnem_t       mn;
    } dec_t;

endpackage

// File: rtl/core/aic_decode.sv
`timescale 1ns / 1ps
// Combinational decode of one instruction word and its address into a dec_t.
// Depends on aic_pkg.
module aic_decode (
    input  logic [31:0]  instr_addr,
    input  logic [31:0]  instr_word,
    output aic_pkg::dec_t dec
);

    function automatic aic_pkg::dec_t shift_imm(input aic_pkg::dec_t din,
                                                input logic [31:0] w);
        aic_pkg::dec_t d;
        d = din;
        d.rm   = w[3:0];
        d.kind = w[6:5];
        if (w[11:7] != 5'd0) begin
            d.form = aic_pkg::FORM_SHIMM;
            d.amt  = {1'b0, w[11:7]};
        end else if (w[6:5] == aic_pkg::SH_LSL) begin
            d.form = aic_pkg::FORM_REG;
        end else if (w[6:5] == aic_pkg::SH_ROR) begin
            d.form = aic_pkg::FORM_RRX;
        end else begin
            d.form = aic_pkg::FORM_SHIMM;
            d.amt  = 6'd32;
        end
        return d;
    endfunction

    function automatic aic_pkg::dec_t shifter(input aic_pkg::dec_t din,
                                              input logic [31:0] w);
        aic_pkg::dec_t d;
        logic [63:0]   dbl;
        d   = din;
        dbl = {24'd0, w[7:0], 24'd0, w[7:0]} >> {w[11:8], 1'b0};
        if (w[25]) begin
            d.form = aic_pkg::FORM_IMM;
            d.val  = dbl[31:0];
        end else if (w[4]) begin
            d.form = aic_pkg::FORM_SHREG;
            d.rm   = w[3:0];
            d.kind = w[6:5];
            d.rs   = w[11:8];
        end else begin
            d = shift_imm(d, w);
        end
        return d;
    endfunction

    logic [31:0] w;
    logic [31:0] pc8;
    logic [31:0] boff;
    logic        load;
    logic        cmp;
    logic        undef;
    aic_pkg::dec_t d;

    assign w    = instr_word;
    assign pc8  = instr_addr + aic_pkg::PC_AHEAD;
    assign boff = {{6{w[23]}}, w[23:0], 2'b00};
    assign load = w[20];
    assign cmp  = (w[24:23] == 2'b10);

    always_comb begin
        d     = '0;
        undef = 1'b0;
        if (w[31:28] == 4'hf) begin
            if (w[27:25] == 3'b101) begin
                d.mn  = aic_pkg::MN_BLX;
                d.tgt = pc8 + boff + {30'd0, w[24], 1'b0};
            end else begin
                undef = 1'b1;
            end
        end else if (w[27:4] == 24'h12fff1) begin
            d.mn   = aic_pkg::MN_BX;
            d.rm   = w[3:0];
            d.form = aic_pkg::FORM_REG;
        end else if (w[27:22] == 6'd0 && w[7:4] == 4'h9) begin
            d.mn        = w[21] ? aic_pkg::MN_MLA : aic_pkg::MN_MUL;
            d.flags[aic_pkg::FB_S] = load;
            d.rd        = w[19:16];
            d.rn        = w[21] ? w[15:12] : 4'd0;
            d.rm        = w[3:0];
            d.rs        = w[11:8];
        end else if (w[27:23] == 5'b00001 && w[7:4] == 4'h9) begin
            d.mn = aic_pkg::MN_UMULL + {4'd0, w[22:21]};
            d.flags[aic_pkg::FB_S] = load;
            d.rd = w[15:12];
            d.rn = w[19:16];
            d.rm = w[3:0];
            d.rs = w[11:8];
        end else if (w[31:20] == 12'he12 && w[7:4] == 4'h7) begin
            d.mn  = aic_pkg::MN_BKPT;
            d.val = {16'd0, w[19:8], w[3:0]};
        end else if (w[27:23] == 5'b00010 && w[21:20] == 2'b00 && w[11:4] == 8'h09) begin
            d.mn = aic_pkg::MN_SWP;
            d.flags[aic_pkg::FB_BL] = w[22];
            d.rd = w[15:12];
            d.rm = w[3:0];
            d.rn = w[19:16];
        end else if (w[27:25] == 3'b000 && w[7] && w[4] && w[6:5] != 2'b00) begin
            if (load) begin
                d.mn = aic_pkg::MN_LDRH0 + {4'd0, w[6:5]};
            end else if (w[6:5] == 2'b01) begin
                d.mn = aic_pkg::MN_STRH;
            end else begin
                // doubleword pair must start on an even register below r14
                undef = w[12] || (w[15:12] == 4'he);
                d.mn  = (w[6:5] == 2'b10) ? aic_pkg::MN_LDRD : aic_pkg::MN_STRD;
            end
            d.rd = w[15:12];
            d.rn = w[19:16];
            d.flags[aic_pkg::FB_P] = w[24];
            d.flags[aic_pkg::FB_U] = w[23];
            d.flags[aic_pkg::FB_W] = w[24] & w[21];
            if (w[22]) begin
                d.form = aic_pkg::FORM_IMM;
                d.val  = {24'd0, w[11:8], w[3:0]};
            end else begin
                d.form = aic_pkg::FORM_REG;
                d.rm   = w[3:0];
            end
        end else if (w[27:23] == 5'b00010 && w[21:16] == 6'b001111 && w[11:0] == 12'd0) begin
            d.mn = aic_pkg::MN_MRS;
            d.rd = w[15:12];
            d.flags[aic_pkg::FB_PSR] = w[22];
        end else if (w[27:26] == 2'b00 && w[24:23] == 2'b10 && w[21:20] == 2'b10
                     && w[15:12] == 4'hf) begin
            d.mn = aic_pkg::MN_MSR;
            d.flags[aic_pkg::FB_PSR] = w[22];
            d.flags[aic_pkg::FB_MF]  = w[19];
            d.flags[aic_pkg::FB_MS]  = w[18];
            d.flags[aic_pkg::FB_MX]  = w[17];
            d.flags[aic_pkg::FB_MC]  = w[16];
            d = shifter(d, w);
        end else begin
            case (w[27:25])
                3'b000, 3'b001: begin
                    // compares without S are undefined
                    undef = cmp && !load;
                    d.mn  = aic_pkg::MN_AND + {2'd0, w[24:21]};
                    d.flags[aic_pkg::FB_S] = load;
                    if (!cmp) begin
                        d.rd = w[15:12];
                    end
                    if (w[24:21] != 4'd13 && w[24:21] != 4'd15) begin
                        d.rn = w[19:16];
                    end
                    d = shifter(d, w);
                end
                3'b010, 3'b011: begin
                    undef = w[25] && w[4];
                    d.mn  = load ? aic_pkg::MN_LDR : aic_pkg::MN_STR;
                    d.flags[aic_pkg::FB_P]  = w[24];
                    d.flags[aic_pkg::FB_U]  = w[23];
                    d.flags[aic_pkg::FB_W]  = w[24] & w[21];
                    d.flags[aic_pkg::FB_BL] = w[22];
                    d.flags[aic_pkg::FB_T]  = !w[24] & w[21];
                    d.rd = w[15:12];
                    d.rn = w[19:16];
                    if (w[25]) begin
                        d = shift_imm(d, w);
                    end else begin
                        d.form = aic_pkg::FORM_IMM;
                        d.val  = {20'd0, w[11:0]};
                        // literal-pool address for pre-indexed pc base
                        if (w[19:16] == 4'hf && w[24]) begin
                            d.tgt = w[23] ? pc8 + {20'd0, w[11:0]}
                                          : pc8 - {20'd0, w[11:0]};
                        end
                    end
                end
                3'b100: begin
                    undef = (w[15:0] == 16'd0);
                    d.mn  = load ? aic_pkg::MN_LDM : aic_pkg::MN_STM;
                    d.rn  = w[19:16];
                    d.val = {16'd0, w[15:0]};
                    d.flags[aic_pkg::FB_P]   = w[24];
                    d.flags[aic_pkg::FB_U]   = w[23];
                    d.flags[aic_pkg::FB_W]   = w[21];
                    d.flags[aic_pkg::FB_PSR] = w[22];
                end
                3'b101: begin
                    d.mn  = w[24] ? aic_pkg::MN_BL : aic_pkg::MN_B;
                    d.tgt = pc8 + boff;
                end
                3'b110: begin
                    d.rs = w[11:8];
                    if (w[24:21] == 4'b0010) begin
                        d.mn  = load ? aic_pkg::MN_MRRC : aic_pkg::MN_MCRR;
                        d.val = {28'd0, w[7:4]};
                        d.rd  = w[15:12];
                        d.rn  = w[19:16];
                        d.rm  = w[3:0];
                    end else begin
                        d.mn = load ? aic_pkg::MN_LDC : aic_pkg::MN_STC;
                        d.flags[aic_pkg::FB_P]  = w[24];
                        d.flags[aic_pkg::FB_U]  = w[23];
                        d.flags[aic_pkg::FB_W]  = w[24] & w[21];
                        d.flags[aic_pkg::FB_BL] = w[22];
                        d.rd   = w[15:12];
                        d.rn   = w[19:16];
                        d.form = aic_pkg::FORM_IMM;
                        d.val  = {22'd0, w[7:0], 2'b00};
                    end
                end
                default: begin
                    if (w[24]) begin
                        d.mn  = aic_pkg::MN_SWI;
                        d.val = {8'd0, w[23:0]};
                    end else begin
                        d.rs = w[11:8];
                        d.rn = w[19:16];
                        d.rm = w[3:0];
                        d.rd = w[15:12];
                        if (w[4]) begin
                            d.mn  = load ? aic_pkg::MN_MRC : aic_pkg::MN_MCR;
                            d.val = {25'd0, w[23:21], 1'b0, w[7:5]};
                        end else begin
                            d.mn  = aic_pkg::MN_CDP;
                            d.val = {24'd0, w[23:20], 1'b0, w[7:5]};
                        end
                    end
                end
            endcase
        end
        if (undef) begin
            d = '0;
        end
        d.cond = w[31:28];
    end

    assign dec = d;

endmodule

// File: rtl/core/arm_instruction_classifier.sv
`timescale 1ns / 1ps
// Top level of the instruction classifier: input register, decode, result
// register. Depends on aic_pkg and aic_decode.
//
//  channel | ports          | tdata bits | fields (lowest bit up)
//  --------+----------------+------------+----------------------------------
//  input   | s_tvalid/ready | 64         | instr_addr[31:0] instr_word[63:32]
//  result  | m_tvalid/ready | 112        | mnemonic condition flag_bits ...
//
// One request per cycle sustained while m_tready is high; each request passes
// from its acceptance to its result through the input register, then the result register.
// The decode is a single pass of combinational logic between the two.
// aresetn (synchronous, active low) clears only the valid bits; no clearing
// pass. A stalled result holds in the result register while the input
// register still takes one more request.
module arm_instruction_classifier (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] instr_addr, [63:32] instr_word
    input  logic [63:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [5:0] mnemonic, [9:6] condition, [20:10] flag_bits, [24:21] reg_dest,
    // [28:25] reg_base, [32:29] reg_second, [36:33] reg_shift_or_cp,
    // [39:37] operand_form, [41:40] shift_kind, [47:42] shift_amount,
    // [79:48] operand_value, [111:80] target_addr
    output logic [111:0] m_tdata
);

    logic          in_valid_reg;
    logic          in_valid_next;
    logic [31:0]   addr_reg;
    logic [31:0]   word_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    aic_pkg::dec_t res_reg;
    aic_pkg::dec_t dec;
    logic          out_free;
    logic          in_free;
    logic          s_take;
    logic          advance;

    // result slot frees when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;
    // input slot frees when empty or moving into the result slot
    assign in_free  = !in_valid_reg || out_free;
    assign s_tready = in_free;
    assign s_take   = s_tvalid && in_free;
    assign advance  = in_valid_reg && out_free;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_free) begin
            in_valid_next = s_tvalid;
        end
        if (out_free) begin
            out_valid_next = in_valid_reg;
        end
    end

    aic_decode u_decode (
        .instr_addr (addr_reg),
        .instr_word (word_reg),
        .dec        (dec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: input registers load on acceptance, result register on advance; hold otherwise
    always_ff @(posedge aclk) begin
        if (s_take) begin
            addr_reg <= s_tdata[31:0];
            word_reg <= s_tdata[63:32];
        end
        if (advance) begin
            res_reg <= dec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.tgt, res_reg.val, res_reg.amt, res_reg.kind,
                       res_reg.form, res_reg.rs, res_reg.rm, res_reg.rn,
                       res_reg.rd, res_reg.flags, res_reg.cond, res_reg.mn};

endmodule
